// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/pal_pkg.sv =====
// package with types and constants for the positional array list
package pal_pkg;

    localparam int CAPACITY   = 16;
    localparam int WORD_BITS  = 32;
    localparam int VALUE_BITS = 32;
    localparam int POS_BITS   = 5;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int ADDR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_BITS   = (COUNT_BITS > POS_BITS) ? COUNT_BITS : POS_BITS;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_WRITE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHIFT,
        S_FILL
    } state_t;

    typedef struct packed {
        op_t                          opcode;
        logic [POS_BITS-1:0]          position;
        logic signed [VALUE_BITS-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] read_value;
        status_t                      status;
        logic [COUNT_BITS-1:0]        count_now;
        logic                         is_empty;
    } result_t;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        logic [WORD_BITS-1:0] wdata;
        logic                 re;
        logic [ADDR_BITS-1:0] raddr;
    } mem_req_t;

endpackage

// ===== rtl/core/positional_array_list_top.sv =====
// top level of the positional array list
// errors, overwrite, insert at the end and remove of the last entry: result in the cycle after start
// read: S_READ, then the result register; insert that moves k entries: S_SHIFT for each entry, then S_FILL;
// remove that moves k entries: S_SHIFT for each entry; k is at most 15, one entry per cycle through the ram
// busy is high while a word is in progress; the next word may start once busy falls
// reset clears the count and the sequencer; list contents are unknown until written
`include "assert_macros.svh"

module positional_array_list_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  pal_pkg::cmd_t    cmd,
    output logic             busy,
    output pal_pkg::result_t result,
    output logic             done
);

    pal_pkg::mem_req_t                mem_req;
    logic [pal_pkg::WORD_BITS-1:0]    rdata;
    logic                             err_word;
    logic                             full_word;
    logic                             at_capacity;
    logic                             accepted;

    pal_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .result  (result),
        .done    (done),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    pal_ram #(
        .DEPTH     (pal_pkg::CAPACITY),
        .WIDTH     (pal_pkg::WORD_BITS),
        .ADDR_BITS (pal_pkg::ADDR_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    assign err_word    = (result.status != pal_pkg::ST_DONE);
    assign full_word   = (result.status == pal_pkg::ST_FULL);
    assign at_capacity = (result.count_now == pal_pkg::COUNT_BITS'(pal_pkg::CAPACITY));
    assign accepted    = start && !busy;

    `ASSERT_IMPLIES(a_empty_flag, clk, rst_n, done, result.is_empty == (result.count_now == '0))
    `ASSERT_IMPLIES(a_err_zero, clk, rst_n, done && err_word, result.read_value == '0)
    `ASSERT_IMPLIES(a_full_count, clk, rst_n, done && full_word, at_capacity)
    `ASSERT_IMPLIES(a_no_strobe_busy, clk, rst_n, done, !busy)
    `ASSERT_NEXT(a_accept_progress, clk, rst_n, accepted, done || busy)

endmodule

// ===== rtl/core/pal_ram.sv =====
// simple dual-port ram, one write and one registered read per cycle
module pal_ram #(
    parameter int DEPTH     = 16,
    parameter int WIDTH     = 32,
    parameter int ADDR_BITS = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pal_ctrl.sv =====
// sequencer: checks positions, shifts entries through the ram, forms results
module pal_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  pal_pkg::cmd_t                       cmd,
    output logic                                busy,
    output pal_pkg::result_t                    result,
    output logic                                done,
    output pal_pkg::mem_req_t                   mem_req,
    input  logic [pal_pkg::WORD_BITS-1:0]       rdata
);

    pal_pkg::state_t                       state_reg, state_next;
    logic [pal_pkg::COUNT_BITS-1:0]        count_reg, count_next;
    logic [pal_pkg::COUNT_BITS-1:0]        left_reg, left_next;
    logic [pal_pkg::ADDR_BITS-1:0]         wr_addr_reg, wr_addr_next;
    logic                                  dir_reg, dir_next;
    logic [pal_pkg::ADDR_BITS-1:0]         pos_reg, pos_next;
    logic [pal_pkg::WORD_BITS-1:0]         val_reg, val_next;
    pal_pkg::result_t                      result_reg, result_next;
    logic                                  done_reg, done_next;
    logic [pal_pkg::CMP_BITS-1:0]          pos_ext, cnt_ext;
    logic [pal_pkg::COUNT_BITS-1:0]        count_inc, count_dec;

    function automatic pal_pkg::result_t make_result(
        input logic [pal_pkg::VALUE_BITS-1:0] rd,
        input pal_pkg::status_t               st,
        input logic [pal_pkg::COUNT_BITS-1:0] cnt
    );
        pal_pkg::result_t r;
        r.read_value = rd;
        r.status     = st;
        r.count_now  = cnt;
        r.is_empty   = (cnt == '0);
        return r;
    endfunction

    assign pos_ext   = pal_pkg::CMP_BITS'(cmd.position);
    assign cnt_ext   = pal_pkg::CMP_BITS'(count_reg);
    assign count_inc = count_reg + pal_pkg::COUNT_BITS'(1);
    assign count_dec = count_reg - pal_pkg::COUNT_BITS'(1);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        left_next    = left_reg;
        wr_addr_next = wr_addr_reg;
        dir_next     = dir_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        result_next  = result_reg;
        done_next    = 1'b0;
        mem_req      = '0;

        case (state_reg)
            pal_pkg::S_IDLE:
            begin
                if (start)
                begin
                    pos_next = pal_pkg::ADDR_BITS'(cmd.position);
                    val_next = pal_pkg::WORD_BITS'($unsigned(cmd.value));
                    if (cmd.opcode == pal_pkg::OP_INSERT)
                    begin
                        if (pos_ext > cnt_ext)
                        begin
                            result_next = make_result('0, pal_pkg::ST_RANGE, count_reg);
                            done_next   = 1'b1;
                        end
                        else if (cnt_ext == pal_pkg::CMP_BITS'(pal_pkg::CAPACITY))
                        begin
                            result_next = make_result('0, pal_pkg::ST_FULL, count_reg);
                            done_next   = 1'b1;
                        end
                        else if (pos_ext == cnt_ext)
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = pal_pkg::ADDR_BITS'(cmd.position);
                            mem_req.wdata = pal_pkg::WORD_BITS'($unsigned(cmd.value));
                            count_next    = count_inc;
                            result_next   = make_result('0, pal_pkg::ST_DONE, count_inc);
                            done_next     = 1'b1;
                        end
                        else
                        begin
                            mem_req.re   = 1'b1;
                            mem_req.raddr = pal_pkg::ADDR_BITS'(count_dec);
                            wr_addr_next = pal_pkg::ADDR_BITS'(count_reg);
                            left_next    = pal_pkg::COUNT_BITS'(cnt_ext - pos_ext);
                            dir_next     = 1'b1;
                            state_next   = pal_pkg::S_SHIFT;
                        end
                    end
                    else if (pos_ext >= cnt_ext)
                    begin
                        result_next = make_result('0, pal_pkg::ST_RANGE, count_reg);
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        case (cmd.opcode)
                            pal_pkg::OP_REMOVE:
                            begin
                                if (pal_pkg::CMP_BITS'(pos_ext + pal_pkg::CMP_BITS'(1)) == cnt_ext)
                                begin
                                    count_next  = count_dec;
                                    result_next = make_result('0, pal_pkg::ST_DONE, count_dec);
                                    done_next   = 1'b1;
                                end
                                else
                                begin
                                    mem_req.re    = 1'b1;
                                    mem_req.raddr = pal_pkg::ADDR_BITS'(cmd.position)
                                                    + pal_pkg::ADDR_BITS'(1);
                                    wr_addr_next  = pal_pkg::ADDR_BITS'(cmd.position);
                                    left_next     = pal_pkg::COUNT_BITS'(cnt_ext - pos_ext
                                                    - pal_pkg::CMP_BITS'(1));
                                    dir_next      = 1'b0;
                                    state_next    = pal_pkg::S_SHIFT;
                                end
                            end
                            pal_pkg::OP_READ:
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = pal_pkg::ADDR_BITS'(cmd.position);
                                state_next    = pal_pkg::S_READ;
                            end
                            pal_pkg::OP_WRITE:
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = pal_pkg::ADDR_BITS'(cmd.position);
                                mem_req.wdata = pal_pkg::WORD_BITS'($unsigned(cmd.value));
                                result_next   = make_result('0, pal_pkg::ST_DONE, count_reg);
                                done_next     = 1'b1;
                            end
                            default:
                            begin
                                result_next = make_result('0, pal_pkg::ST_DONE, count_reg);
                                done_next   = 1'b1;
                            end
                        endcase
                    end
                end
            end

            pal_pkg::S_READ:
            begin
                result_next = make_result(pal_pkg::VALUE_BITS'(rdata), pal_pkg::ST_DONE,
                                          count_reg);
                done_next   = 1'b1;
                state_next  = pal_pkg::S_IDLE;
            end

            // one entry moved per cycle; reads run ahead of writes, never the same entry
            pal_pkg::S_SHIFT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = wr_addr_reg;
                mem_req.wdata = rdata;
                mem_req.re    = (left_reg != pal_pkg::COUNT_BITS'(1));
                left_next     = left_reg - pal_pkg::COUNT_BITS'(1);
                if (dir_reg)
                begin
                    wr_addr_next  = wr_addr_reg - pal_pkg::ADDR_BITS'(1);
                    mem_req.raddr = wr_addr_reg - pal_pkg::ADDR_BITS'(2);
                end
                else
                begin
                    wr_addr_next  = wr_addr_reg + pal_pkg::ADDR_BITS'(1);
                    mem_req.raddr = wr_addr_reg + pal_pkg::ADDR_BITS'(2);
                end
                if (left_reg == pal_pkg::COUNT_BITS'(1))
                begin
                    if (dir_reg)
                    begin
                        state_next = pal_pkg::S_FILL;
                    end
                    else
                    begin
                        count_next  = count_dec;
                        result_next = make_result('0, pal_pkg::ST_DONE, count_dec);
                        done_next   = 1'b1;
                        state_next  = pal_pkg::S_IDLE;
                    end
                end
            end

            pal_pkg::S_FILL:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                mem_req.wdata = val_reg;
                count_next    = count_inc;
                result_next   = make_result('0, pal_pkg::ST_DONE, count_inc);
                done_next     = 1'b1;
                state_next    = pal_pkg::S_IDLE;
            end

            default:
            begin
                state_next = pal_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pal_pkg::S_IDLE;
            count_reg   <= '0;
            left_reg    <= '0;
            wr_addr_reg <= '0;
            dir_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            wr_addr_reg <= wr_addr_next;
            dir_reg     <= dir_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != pal_pkg::S_IDLE);
    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ===== sim/positional_array_list_top_tb.sv =====
// self-checking testbench for the positional array list
module positional_array_list_top_tb;

    localparam int ITEMS = 1700;
    localparam int LIMIT = 250000;
    localparam int TAIL  = 20;

    class list_scoreboard;
        logic signed [pal_pkg::VALUE_BITS-1:0] slots [pal_pkg::CAPACITY];
        int fill;
        int errors;
        pal_pkg::result_t awaited [$];

        function new();
            fill = 0;
            errors = 0;
        endfunction

        function void note(pal_pkg::cmd_t c);
            pal_pkg::result_t r;
            int i;
            r = '0;
            r.status = pal_pkg::ST_DONE;
            if (c.opcode == pal_pkg::OP_INSERT)
            begin
                if (c.position > fill)
                    r.status = pal_pkg::ST_RANGE;
                else if (fill >= pal_pkg::CAPACITY)
                    r.status = pal_pkg::ST_FULL;
                else
                begin
                    for (i = fill; i > c.position; i--)
                        slots[i] = slots[i - 1];
                    slots[c.position] = c.value;
                    fill++;
                end
            end
            else if (c.position >= fill)
                r.status = pal_pkg::ST_RANGE;
            else if (c.opcode == pal_pkg::OP_REMOVE)
            begin
                for (i = c.position; i + 1 < fill; i++)
                    slots[i] = slots[i + 1];
                fill--;
            end
            else if (c.opcode == pal_pkg::OP_READ)
                r.read_value = slots[c.position];
            else
                slots[c.position] = c.value;
            r.count_now = pal_pkg::COUNT_BITS'(fill);
            r.is_empty = (fill == 0);
            awaited.push_back(r);
        endfunction

        function void check(pal_pkg::result_t got);
            pal_pkg::result_t e;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                         $time, got.read_value, got.status);
                return;
            end
            e = awaited.pop_front();
            if (got.read_value !== e.read_value)
            begin
                errors++;
                $display("%0t: read_value expected %0d actual %0d",
                         $time, e.read_value, got.read_value);
            end
            if (got.status !== e.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
            end
            if (got.count_now !== e.count_now)
            begin
                errors++;
                $display("%0t: count_now expected %0d actual %0d",
                         $time, e.count_now, got.count_now);
            end
            if (got.is_empty !== e.is_empty)
            begin
                errors++;
                $display("%0t: is_empty expected %0d actual %0d",
                         $time, e.is_empty, got.is_empty);
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    pal_pkg::cmd_t    cmd;
    logic             busy;
    pal_pkg::result_t result;
    logic             done;
    int               cycles = 0;

    list_scoreboard sb = new();

    positional_array_list_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .result (result),
        .done   (done)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("positional_array_list_top_tb: done, errors");
            $finish;
        end
    end

    // results first, then the word accepted at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check(result);
            if (start && !busy)
                sb.note(cmd);
        end
    end

    function automatic pal_pkg::cmd_t word_of(pal_pkg::op_t op, int pos,
                                              logic [pal_pkg::VALUE_BITS-1:0] v);
        pal_pkg::cmd_t c;
        c.opcode = op;
        c.position = pal_pkg::POS_BITS'(pos);
        c.value = v;
        return c;
    endfunction

    function automatic logic [pal_pkg::VALUE_BITS-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // mostly legal positions, biased towards filling or draining the list
    function automatic pal_pkg::cmd_t pick_word(int fill, bit growing);
        pal_pkg::cmd_t c;
        int r;
        r = $urandom_range(99);
        if (r < 10)
            c.opcode = pal_pkg::op_t'($urandom_range(3));
        else if (r < 55)
            c.opcode = growing ? pal_pkg::OP_INSERT : pal_pkg::OP_REMOVE;
        else if (r < 70)
            c.opcode = growing ? pal_pkg::OP_REMOVE : pal_pkg::OP_INSERT;
        else if (r < 85)
            c.opcode = pal_pkg::OP_READ;
        else
            c.opcode = pal_pkg::OP_WRITE;
        if ($urandom_range(11) == 0)
            c.position = pal_pkg::POS_BITS'($urandom_range(31));
        else if (c.opcode == pal_pkg::OP_INSERT)
            c.position = pal_pkg::POS_BITS'($urandom_range(fill));
        else
            c.position = (fill == 0) ? '0 : pal_pkg::POS_BITS'($urandom_range(fill - 1));
        c.value = pick_value();
        return c;
    endfunction

    // called just after a falling edge
    task automatic push_word(pal_pkg::cmd_t c);
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send(pal_pkg::cmd_t c);
        @(negedge clk);
        push_word(c);
    endtask

    task automatic pause(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int i;
        int run_left;
        bit growing;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list
        send(word_of(pal_pkg::OP_READ, 0, '0));
        send(word_of(pal_pkg::OP_REMOVE, 0, '0));
        send(word_of(pal_pkg::OP_INSERT, 1, 32'h1234_5678));
        send(word_of(pal_pkg::OP_WRITE, 0, '1));
        // fill at front, back and middle
        send(word_of(pal_pkg::OP_INSERT, 0, 32'h8000_0000));
        send(word_of(pal_pkg::OP_INSERT, 1, 32'h7fff_ffff));
        send(word_of(pal_pkg::OP_INSERT, 1, '0));
        send(word_of(pal_pkg::OP_INSERT, 0, '1));
        for (i = 4; i < pal_pkg::CAPACITY; i++)
            send(word_of(pal_pkg::OP_INSERT, $urandom_range(i), $urandom));
        // full list
        send(word_of(pal_pkg::OP_INSERT, pal_pkg::CAPACITY, 32'h5555_aaaa));
        send(word_of(pal_pkg::OP_INSERT, pal_pkg::CAPACITY + 1, 32'haaaa_5555));
        send(word_of(pal_pkg::OP_READ, pal_pkg::CAPACITY - 1, '0));
        send(word_of(pal_pkg::OP_READ, pal_pkg::CAPACITY, '0));
        send(word_of(pal_pkg::OP_WRITE, 0, $urandom));
        send(word_of(pal_pkg::OP_REMOVE, pal_pkg::CAPACITY - 1, '0));
        send(word_of(pal_pkg::OP_REMOVE, 0, '0));
        send(word_of(pal_pkg::OP_READ, 0, '0));
        drain();

        run_left = 0;
        growing = 1'b1;
        for (i = 0; i < ITEMS; i++)
        begin
            if (run_left == 0)
            begin
                if ($urandom_range(3) != 0)
                    pause($urandom_range(1, 10));
                run_left = ($urandom_range(4) == 0) ? $urandom_range(40, 80)
                                                    : $urandom_range(1, 16);
            end
            run_left--;
            if (i % 400 == 399)
                drain();
            @(negedge clk);
            if (sb.fill == pal_pkg::CAPACITY)
                growing = 1'b0;
            else if (sb.fill == 0)
                growing = 1'b1;
            else if ($urandom_range(63) == 0)
                growing = !growing;
            push_word(pick_word(sb.fill, growing));
        end

        drain();
        repeat (TAIL) @(posedge clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("positional_array_list_top_tb: done, clean");
        else
            $display("positional_array_list_top_tb: done, errors");
        $finish;
    end

endmodule
